// ----- rtl/dda_pkg.sv -----
// ----------------------------------------------------------------------------
// DDA line point generator package
// Shared widths, the line descriptor passed from front to back, and the
// back-end state type.
// ----------------------------------------------------------------------------
package dda_pkg;

    localparam int COORD_BITS   = 6;
    localparam int FRAC_BITS    = 8;
    localparam int POINT_BITS   = COORD_BITS + FRAC_BITS;
    localparam int DIV_BITS     = COORD_BITS + FRAC_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_BITS);
    localparam int Q_DEPTH      = 2;
    localparam int Q_PTR_BITS   = 1;
    localparam int Q_LVL_BITS   = 2;

    // One classified line: start point, per-axis magnitude and direction,
    // and the step count (larger of the two magnitudes).
    typedef struct packed {
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
        logic [COORD_BITS-1:0] adx;
        logic [COORD_BITS-1:0] ady;
        logic [COORD_BITS-1:0] steps;
        logic                  negx;
        logic                  negy;
    } dda_line_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_EMIT
    } bk_state_t;

endpackage

// ----- rtl/dda_line_point_generator.sv -----
// ----------------------------------------------------------------------------
// DDA line point generator
// Takes a line by its integer end points and emits every point along it in
// unsigned fixed point, flagging the final point.
// ----------------------------------------------------------------------------
// Path: an accepted line passes the front register and the queue, then the
// serial divide before its first point; a zero-length line skips the divide.
// Throughput: one point per cycle while out_ready holds; a line occupies the back
// end through the bit-serial divide and the point walk before the next is taken.
// The front accepts up to three lines ahead while the back end is busy.
// Reset: rst_n clears all handshake and state control asynchronously.
module dda_line_point_generator
    import dda_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [POINT_BITS-1:0] point_x,
    output logic [POINT_BITS-1:0] point_y,
    output logic                  last_point
);

    logic                  push_valid;
    logic                  push_ready;
    dda_line_t             push_data;
    logic                  pop_valid;
    logic                  pop_ready;
    dda_line_t             pop_data;
    logic [Q_LVL_BITS-1:0] q_level;
    logic                  line_start_reg;

    dda_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    dda_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .level      (q_level)
    );

    dda_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .point_x    (point_x),
        .point_y    (point_y),
        .last_point (last_point)
    );

    // Tracks whether the next point shown is the first of a line.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_start_reg <= 1'b1;
        end
        else if (out_valid && out_ready)
        begin
            line_start_reg <= last_point;
        end
    end

    // The first point of every line is the integer start point.
    a_first_point_integer : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_start_reg |->
            point_x[FRAC_BITS-1:0] == '0 && point_y[FRAC_BITS-1:0] == '0)
        else $error("first point of a line has nonzero fraction bits");

    // Points within a line follow back to back with no gap.
    a_no_gap_in_line : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_point |=> out_valid)
        else $error("gap inside a line");

    // The queue never holds more lines than it has entries.
    a_queue_bound : assert property (@(posedge clk) disable iff (!rst_n)
        q_level <= Q_LVL_BITS'(Q_DEPTH))
        else $error("line queue overflow");

    // A stalled front end means the queue is full.
    a_front_stall : assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> q_level == Q_LVL_BITS'(Q_DEPTH))
        else $error("front stalled with room in the queue");

endmodule

// ----- rtl/dda_front.sv -----
// ----------------------------------------------------------------------------
// DDA front end
// Accepts line requests, computes direction, magnitudes and step count, and
// holds the classified line in a register until the queue takes it.
// ----------------------------------------------------------------------------
module dda_front
    import dda_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    output logic                  push_valid,
    input  logic                  push_ready,
    output dda_line_t             push_data
);

    logic      valid_reg;
    logic      valid_next;
    dda_line_t line_reg;
    dda_line_t line_next;
    logic      negx;
    logic      negy;
    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;

    always_comb
    begin
        negx = end_x < start_x;
        negy = end_y < start_y;
        adx  = negx ? (start_x - end_x) : (end_x - start_x);
        ady  = negy ? (start_y - end_y) : (end_y - start_y);

        line_next.sx    = start_x;
        line_next.sy    = start_y;
        line_next.adx   = adx;
        line_next.ady   = ady;
        line_next.steps = (adx > ady) ? adx : ady;
        line_next.negx  = negx;
        line_next.negy  = negy;
    end

    assign in_ready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_data  = line_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            line_reg <= line_next;
        end
    end

endmodule

// ----- rtl/dda_queue.sv -----
// ----------------------------------------------------------------------------
// DDA line queue
// Two-entry first-in first-out buffer of classified lines between the front
// and back ends.
// ----------------------------------------------------------------------------
module dda_queue
    import dda_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  dda_line_t             push_data,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output dda_line_t             pop_data,
    output logic [Q_LVL_BITS-1:0] level
);

    dda_line_t             entry_reg [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] wr_ptr_reg;
    logic [Q_PTR_BITS-1:0] wr_ptr_next;
    logic [Q_PTR_BITS-1:0] rd_ptr_reg;
    logic [Q_PTR_BITS-1:0] rd_ptr_next;
    logic [Q_LVL_BITS-1:0] level_reg;
    logic [Q_LVL_BITS-1:0] level_next;
    logic                  do_push;
    logic                  do_pop;

    assign push_ready = level_reg != Q_LVL_BITS'(Q_DEPTH);
    assign pop_valid  = level_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign level      = level_reg;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/dda_back.sv -----
// ----------------------------------------------------------------------------
// DDA back end
// Divides both axis magnitudes by the step count with two bit-serial restoring
// dividers that share one counter, then walks the line one point per cycle into
// an output register while that register is free.
// ----------------------------------------------------------------------------
module dda_back
    import dda_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  dda_line_t             pop_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [POINT_BITS-1:0] point_x,
    output logic [POINT_BITS-1:0] point_y,
    output logic                  last_point
);

    bk_state_t               state_reg;
    bk_state_t               state_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic [DIV_CNT_BITS-1:0] cnt_next;
    logic [COORD_BITS-1:0]   steps_reg;
    logic [COORD_BITS-1:0]   steps_next;
    logic [COORD_BITS-1:0]   idx_reg;
    logic [COORD_BITS-1:0]   idx_next;
    logic                    negx_reg;
    logic                    negx_next;
    logic                    negy_reg;
    logic                    negy_next;
    // Dividend registers turn into quotient registers as bits shift through.
    logic [DIV_BITS-1:0]     quox_reg;
    logic [DIV_BITS-1:0]     quox_next;
    logic [DIV_BITS-1:0]     quoy_reg;
    logic [DIV_BITS-1:0]     quoy_next;
    logic [COORD_BITS-1:0]   remx_reg;
    logic [COORD_BITS-1:0]   remx_next;
    logic [COORD_BITS-1:0]   remy_reg;
    logic [COORD_BITS-1:0]   remy_next;
    logic [POINT_BITS-1:0]   px_reg;
    logic [POINT_BITS-1:0]   px_next;
    logic [POINT_BITS-1:0]   py_reg;
    logic [POINT_BITS-1:0]   py_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [POINT_BITS-1:0]   out_x_reg;
    logic [POINT_BITS-1:0]   out_x_next;
    logic [POINT_BITS-1:0]   out_y_reg;
    logic [POINT_BITS-1:0]   out_y_next;
    logic                    out_last_reg;
    logic                    out_last_next;

    logic [COORD_BITS:0]     shx;
    logic [COORD_BITS:0]     shy;
    logic [COORD_BITS:0]     subx;
    logic [COORD_BITS:0]     suby;
    logic                    fitx;
    logic                    fity;
    logic [POINT_BITS-1:0]   incx;
    logic [POINT_BITS-1:0]   incy;
    logic                    out_free;
    logic                    is_last;

    assign out_valid  = out_valid_reg;
    assign point_x    = out_x_reg;
    assign point_y    = out_y_reg;
    assign last_point = out_last_reg;

    always_comb
    begin
        shx  = {remx_reg, quox_reg[DIV_BITS-1]};
        shy  = {remy_reg, quoy_reg[DIV_BITS-1]};
        subx = shx - {1'b0, steps_reg};
        suby = shy - {1'b0, steps_reg};
        fitx = shx >= {1'b0, steps_reg};
        fity = shy >= {1'b0, steps_reg};
        // Quotient never exceeds one pixel, so it fits the point width.
        incx = negx_reg ? (POINT_BITS'(0) - quox_reg) : quox_reg;
        incy = negy_reg ? (POINT_BITS'(0) - quoy_reg) : quoy_reg;
        out_free = !out_valid_reg || out_ready;
        is_last  = idx_reg == steps_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        steps_next     = steps_reg;
        idx_next       = idx_reg;
        negx_next      = negx_reg;
        negy_next      = negy_reg;
        quox_next      = quox_reg;
        quoy_next      = quoy_reg;
        remx_next      = remx_reg;
        remy_next      = remy_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_last_next  = out_last_reg;
        pop_ready      = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    steps_next = pop_data.steps;
                    negx_next  = pop_data.negx;
                    negy_next  = pop_data.negy;
                    quox_next  = {pop_data.adx, FRAC_BITS'(0)};
                    quoy_next  = {pop_data.ady, FRAC_BITS'(0)};
                    remx_next  = '0;
                    remy_next  = '0;
                    px_next    = {pop_data.sx, FRAC_BITS'(0)};
                    py_next    = {pop_data.sy, FRAC_BITS'(0)};
                    idx_next   = '0;
                    cnt_next   = DIV_CNT_BITS'(DIV_BITS - 1);
                    // A zero-length line has no division; its increments are zero.
                    if (pop_data.steps == '0)
                    begin
                        quox_next  = '0;
                        quoy_next  = '0;
                        state_next = BK_EMIT;
                    end
                    else
                    begin
                        state_next = BK_DIV;
                    end
                end
            end

            BK_DIV:
            begin
                remx_next = fitx ? subx[COORD_BITS-1:0] : shx[COORD_BITS-1:0];
                remy_next = fity ? suby[COORD_BITS-1:0] : shy[COORD_BITS-1:0];
                quox_next = {quox_reg[DIV_BITS-2:0], fitx};
                quoy_next = {quoy_reg[DIV_BITS-2:0], fity};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = BK_EMIT;
                end
            end

            BK_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = px_reg;
                    out_y_next     = py_reg;
                    out_last_next  = is_last;
                    px_next        = px_reg + incx;
                    py_next        = py_reg + incy;
                    idx_next       = idx_reg + 1'b1;
                    if (is_last)
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        steps_reg    <= steps_next;
        idx_reg      <= idx_next;
        negx_reg     <= negx_next;
        negy_reg     <= negy_next;
        quox_reg     <= quox_next;
        quoy_reg     <= quoy_next;
        remx_reg     <= remx_next;
        remy_reg     <= remy_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_last_reg <= out_last_next;
    end

endmodule

// ----- verif/dda_line_point_generator_tb.sv -----
// ----------------------------------------------------------------------------
// DDA line point generator testbench
// Feeds line requests through a valid/ready driver and compares every point
// that leaves the block with points predicted from the line end points.
// Both sides idle at random, the receiver holds off once for a long stretch
// and the sender pauses once or more until the block has drained.
// ----------------------------------------------------------------------------
module dda_line_point_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dda_pkg::*;

    localparam int N_RANDOM    = 390;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 800;
    localparam int MAX_PRINTS  = 40;

    typedef struct packed {
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
        logic [COORD_BITS-1:0] ex;
        logic [COORD_BITS-1:0] ey;
        logic                  drain_first;
    } line_req_t;

    typedef struct packed {
        logic [POINT_BITS-1:0] x;
        logic [POINT_BITS-1:0] y;
        logic                  last;
    } line_point_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic                  out_valid;
    logic                  out_ready;
    logic [POINT_BITS-1:0] point_x;
    logic [POINT_BITS-1:0] point_y;
    logic                  last_point;

    line_req_t   line_reqs[$];
    line_point_t exp_points[$];
    int          lines_sent   = 0;
    int          lines_taken  = 0;
    int          mismatch_cnt = 0;
    int          stall_cycles = 0;
    bit          rx_hold      = 0;

    dda_line_point_generator u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .point_x    (point_x),
        .point_y    (point_y),
        .last_point (last_point)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Both sides run without random idling over this window of requests.
    function automatic bit quiet_window();
        return lines_taken >= 200 && lines_taken < 280;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_cnt < MAX_PRINTS)
            $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_cnt++;
    endtask

    task automatic queue_line(input int sx, input int sy, input int ex, input int ey,
                              input bit drain_first);
        line_req_t req;
        req.sx          = COORD_BITS'(sx);
        req.sy          = COORD_BITS'(sy);
        req.ex          = COORD_BITS'(ex);
        req.ey          = COORD_BITS'(ey);
        req.drain_first = drain_first;
        line_reqs.push_back(req);
    endtask

    // Walks the line in fixed point; increments truncate toward zero.
    task automatic predict_line_points(input logic [COORD_BITS-1:0] sx,
                                       input logic [COORD_BITS-1:0] sy,
                                       input logic [COORD_BITS-1:0] ex,
                                       input logic [COORD_BITS-1:0] ey);
        int          dx;
        int          dy;
        int          adx;
        int          ady;
        int          steps;
        int          incx;
        int          incy;
        int          px;
        int          py;
        line_point_t pt;
        dx    = int'(ex) - int'(sx);
        dy    = int'(ey) - int'(sy);
        adx   = dx < 0 ? -dx : dx;
        ady   = dy < 0 ? -dy : dy;
        steps = adx > ady ? adx : ady;
        incx  = 0;
        incy  = 0;
        if (steps > 0)
        begin
            incx = (adx << FRAC_BITS) / steps;
            incy = (ady << FRAC_BITS) / steps;
            if (dx < 0)
                incx = -incx;
            if (dy < 0)
                incy = -incy;
        end
        px = int'(sx) << FRAC_BITS;
        py = int'(sy) << FRAC_BITS;
        for (int i = 0; i <= steps; i++)
        begin
            pt.x    = POINT_BITS'(px);
            pt.y    = POINT_BITS'(py);
            pt.last = (i == steps);
            exp_points.push_back(pt);
            px += incx;
            py += incy;
        end
    endtask

    // Driver: a new request goes out only once the previous one was taken.
    always @(negedge clk)
    begin : drive_lines
        line_req_t req;
        if (rst_n)
        begin
            if (!in_valid || lines_taken == lines_sent)
            begin
                if (line_reqs.size() != 0 &&
                    !(line_reqs[0].drain_first &&
                      (lines_taken != lines_sent || exp_points.size() != 0)) &&
                    (quiet_window() || $urandom_range(99) >= 13))
                begin
                    req = line_reqs.pop_front();
                    start_x  <= req.sx;
                    start_y  <= req.sy;
                    end_x    <= req.ex;
                    end_y    <= req.ey;
                    in_valid <= 1'b1;
                    lines_sent++;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            out_ready <= !rx_hold && (quiet_window() || $urandom_range(99) >= 13);
    end

    // Monitor: checks an outgoing point first, then predicts an accepted line.
    always @(posedge clk)
    begin : watch_ports
        line_point_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (exp_points.size() == 0)
                begin
                    report_mismatch("unexpected point x", point_x, 0);
                end
                else
                begin
                    want = exp_points.pop_front();
                    if (point_x !== want.x)
                        report_mismatch("point_x", point_x, want.x);
                    if (point_y !== want.y)
                        report_mismatch("point_y", point_y, want.y);
                    if (last_point !== want.last)
                        report_mismatch("last_point", last_point, want.last);
                end
            end
            if (in_valid && in_ready)
            begin
                predict_line_points(start_x, start_y, end_x, end_y);
                lines_taken++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // The receiver stops once for long enough that the block backs up.
    initial
    begin : rx_long_hold
        while (lines_taken < 60)
            @(posedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
    end

    initial
    begin : stimulus
        int kind;
        int sx;
        int sy;
        int ex;
        int ey;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        out_ready = 1'b0;
        start_x   = '0;
        start_y   = '0;
        end_x     = '0;
        end_y     = '0;

        // Zero-length lines, full diagonals, edges, single steps, odd slopes.
        queue_line(0, 0, 0, 0, 0);
        queue_line(63, 63, 63, 63, 0);
        queue_line(17, 42, 17, 42, 0);
        queue_line(0, 0, 63, 63, 0);
        queue_line(63, 63, 0, 0, 0);
        queue_line(0, 63, 63, 0, 0);
        queue_line(63, 0, 0, 63, 0);
        queue_line(0, 5, 63, 5, 0);
        queue_line(63, 5, 0, 5, 0);
        queue_line(5, 0, 5, 63, 0);
        queue_line(5, 63, 5, 0, 0);
        queue_line(10, 10, 11, 10, 0);
        queue_line(10, 10, 9, 11, 0);
        queue_line(0, 0, 63, 1, 0);
        queue_line(0, 0, 1, 63, 0);
        queue_line(63, 63, 1, 62, 0);
        queue_line(0, 0, 7, 3, 0);
        queue_line(7, 3, 0, 0, 0);
        queue_line(21, 0, 0, 62, 0);
        queue_line(42, 42, 42, 42, 1);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            kind = $urandom_range(99);
            sx   = $urandom_range(63);
            sy   = $urandom_range(63);
            if (kind < 45)
            begin
                ex = $urandom_range(63);
                ey = $urandom_range(63);
            end
            else if (kind < 75)
            begin
                ex = sx + $urandom_range(6) - 3;
                ey = sy + $urandom_range(6) - 3;
                ex = ex < 0 ? 0 : (ex > 63 ? 63 : ex);
                ey = ey < 0 ? 0 : (ey > 63 ? 63 : ey);
            end
            else if (kind < 85)
            begin
                ex = sx;
                ey = sy;
            end
            else
            begin
                sx = 63 * $urandom_range(1);
                sy = 63 * $urandom_range(1);
                ex = 63 * $urandom_range(1);
                ey = 63 * $urandom_range(1);
            end
            queue_line(sx, sy, ex, ey, i == 100 || $urandom_range(99) < 2);
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (line_reqs.size() != 0 || lines_taken != lines_sent)
            @(posedge clk);
        while (exp_points.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- dda_line_point_generator.f -----
rtl/dda_pkg.sv
rtl/dda_front.sv
rtl/dda_queue.sv
rtl/dda_back.sv
rtl/dda_line_point_generator.sv
verif/dda_line_point_generator_tb.sv
